// File: rtl/core/rpn_pkg.sv
`default_nettype none

package rpn_pkg;

    typedef enum logic [2:0] {
        CMD_PUSH = 3'd0,
        CMD_ADD  = 3'd1,
        CMD_SUB  = 3'd2,
        CMD_MUL  = 3'd3,
        CMD_DIV  = 3'd4,
        CMD_POW  = 3'd5,
        CMD_FIN  = 3'd6,
        CMD_NOP  = 3'd7
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FINAL    = 3'd1,
        ST_UNDER    = 3'd2,
        ST_OVER     = 3'd3,
        ST_DIVZ     = 3'd4,
        ST_NONWHOLE = 3'd5,
        ST_NOINPUT  = 3'd6,
        ST_UNUSED   = 3'd7
    } status_t;

    typedef enum logic [11:0] {
        S_IDLE = 12'b0000_0000_0001,
        S_RDB  = 12'b0000_0000_0010,
        S_RDA  = 12'b0000_0000_0100,
        S_OPA  = 12'b0000_0000_1000,
        S_EXEC = 12'b0000_0001_0000,
        S_MUL  = 12'b0000_0010_0000,
        S_MRND = 12'b0000_0100_0000,
        S_POW  = 12'b0000_1000_0000,
        S_DIV  = 12'b0001_0000_0000,
        S_RDT  = 12'b0010_0000_0000,
        S_TOP  = 12'b0100_0000_0000,
        S_DONE = 12'b1000_0000_0000
    } state_t;

    localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
    localparam logic [31:0] MAX_POS   = 32'h7FFF_FFFF;

endpackage

`default_nettype wire

// File: rtl/core/rpn_div.sv
`default_nettype none

module rpn_div #(
    parameter int NW = 48
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [31:0]   den,
    output logic          busy,
    output logic          done,
    output logic [NW-1:0] quo
);
    import rpn_pkg::*;

    localparam int CNW = $clog2(NW + 1);

    logic [CNW-1:0] cnt_reg;
    logic [31:0]    rem_reg;
    logic [31:0]    den_reg;
    logic [NW-1:0]  num_reg;
    logic [NW-1:0]  quo_reg;
    logic           busy_reg;
    logic           done_reg;
    logic [32:0]    rem_sh;
    logic           ge;
    logic [32:0]    rem_sub;

    // The remainder stays below the divisor, which is at most two to the 31.
    assign rem_sh  = {rem_reg, num_reg[NW-1]};
    assign ge      = rem_sh >= {1'b0, den_reg};
    assign rem_sub = rem_sh - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                num_reg  <= num;
                den_reg  <= den;
                rem_reg  <= '0;
                quo_reg  <= '0;
                cnt_reg  <= CNW'(NW);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg <= ge ? rem_sub[31:0] : rem_sh[31:0];
                num_reg <= {num_reg[NW-2:0], 1'b0};
                quo_reg <= {quo_reg[NW-2:0], ge};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire

// File: rtl/core/rpn_stack_calculator_unit.sv
`default_nettype none
// Flow: push, no-op on an empty stack, and error or finish on an empty or crowded stack go
// straight to the result; finish and no-op read the top; add and subtract read both operands;
// multiply adds a multiply and a rounding state; divide runs the serial divider. Power takes
// a step and up to two multiplies per exponent bit, plus a divide for a negative exponent.
// Throughput: one item at a time; the shared multiplier and the one-bit-per-cycle divider set it.
// Reset: asynchronous, active low; the stack empties and the tolerance returns to 6.
module rpn_stack_calculator_unit #(
    parameter int STACK_DEPTH = 3,
    parameter int FRAC_BITS   = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [14:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // operand[31:0]
    input  logic [2:0]  s_tuser,   // cmd[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // value[31:0], depth[33:32], zeros above
    output logic [2:0]  m_tuser    // status[2:0]
);
    import rpn_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int NW = 32 + FRAC_BITS;
    localparam int EW = 33 - FRAC_BITS;
    localparam logic [31:0]   ONE     = 32'(1) << FRAC_BITS;
    localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);
    localparam logic [CW-1:0] TWO_C   = CW'(2);

    function automatic logic [31:0] mag(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    function automatic logic [31:0] from_mag(input logic neg, input logic [31:0] m);
        if (neg)
            return (m >= MAG_LIMIT) ? MAG_LIMIT : (~m + 32'd1);
        return (m > MAX_POS) ? MAX_POS : m;
    endfunction

    function automatic logic [31:0] sat33(input logic [32:0] s);
        case (s[32:31])
            2'b01:   return MAX_POS;
            2'b10:   return MAG_LIMIT;
            default: return s[31:0];
        endcase
    endfunction

    logic [31:0] stack_mem [STACK_DEPTH];

    state_t      state_reg;
    cmd_t        cmd_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] new_count_reg;
    logic [14:0] tol_reg;
    logic [31:0] a_reg, b_reg, acc_reg, base_reg, rd_data_reg, res_value_reg;
    logic [EW-1:0] e_reg;
    logic        neg_reg, bneg_reg, phase_acc_reg, wr_reg;
    logic [63:0] prod_reg;
    status_t     res_status_reg, out_status_reg;
    logic [31:0] out_value_reg;
    logic [1:0]  out_depth_reg;
    logic        out_valid_reg;
    logic        div_start_reg;
    logic [NW-1:0] div_num_reg;
    logic [31:0] div_den_reg;

    logic [CW-1:0] cm1, cm2, wr_cnt;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [31:0] mag_a, mag_b, mul_x, mul_r, qc;
    logic [63:0] prod_c;
    logic [64:0] rnd_c, rsh;
    logic [32:0] sum33, diff33;
    logic [FRAC_BITS-1:0] pf;
    logic        up, bad, out_free, div_busy, div_done;
    logic [EW-1:0] pe, e_shift;
    logic [FRAC_BITS:0] pdist;
    logic [NW-1:0] div_quo, recip_num, quot_num;

    assign cm1     = count_reg - 1'b1;
    assign cm2     = count_reg - TWO_C;
    assign wr_cnt  = new_count_reg - 1'b1;
    assign rd_addr = (state_reg == S_RDA) ? cm2[AW-1:0] : cm1[AW-1:0];
    assign wr_addr = wr_cnt[AW-1:0];

    assign mag_a  = mag(a_reg);
    assign mag_b  = mag(b_reg);
    assign sum33  = {a_reg[31], a_reg} + {b_reg[31], b_reg};
    assign diff33 = {a_reg[31], a_reg} - {b_reg[31], b_reg};

    assign mul_x  = phase_acc_reg ? acc_reg : base_reg;
    assign prod_c = mul_x * base_reg;
    assign rnd_c  = {1'b0, prod_reg} + 65'(ONE >> 1);
    assign rsh    = rnd_c >> FRAC_BITS;
    assign mul_r  = (rsh > 65'(MAG_LIMIT)) ? MAG_LIMIT : rsh[31:0];

    // Exponent rounds half away from zero to its whole number.
    assign pf      = mag_b[FRAC_BITS-1:0];
    assign up      = pf[FRAC_BITS-1];
    assign pe      = {1'b0, mag_b[31:FRAC_BITS]} + EW'(up);
    assign pdist   = up ? (((FRAC_BITS+1)'(1) << FRAC_BITS) - {1'b0, pf}) : {1'b0, pf};
    assign bad     = 32'(pdist) > 32'(tol_reg);
    assign e_shift = e_reg >> 1;

    assign recip_num = (NW'(1) << (2 * FRAC_BITS)) + NW'(acc_reg >> 1);
    assign quot_num  = (NW'(mag_a) << FRAC_BITS) + NW'(mag_b >> 1);
    assign qc        = (div_quo > NW'(MAG_LIMIT)) ? MAG_LIMIT : div_quo[31:0];

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);

    rpn_div #(.NW(NW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .num   (div_num_reg),
        .den   (div_den_reg),
        .busy  (div_busy),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_ff @(posedge clk)
    begin
        rd_data_reg <= stack_mem[rd_addr];
        if (state_reg == S_DONE && out_free && wr_reg)
            stack_mem[wr_addr] <= res_value_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            tol_reg       <= 15'd6;
            out_valid_reg <= 1'b0;
            div_start_reg <= 1'b0;
            wr_reg        <= 1'b0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            if (cfg_we)
                tol_reg <= cfg_wdata;
            if (out_valid_reg && m_tready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        cmd_reg        <= cmd_t'(s_tuser);
                        wr_reg         <= 1'b0;
                        res_value_reg  <= '0;
                        new_count_reg  <= '0;
                        res_status_reg <= ST_OK;
                        state_reg      <= S_DONE;
                        unique case (cmd_t'(s_tuser)) inside
                            CMD_PUSH:
                            begin
                                if (count_reg >= DEPTH_C)
                                    res_status_reg <= ST_OVER;
                                else
                                begin
                                    res_value_reg <= s_tdata;
                                    wr_reg        <= 1'b1;
                                    new_count_reg <= count_reg + 1'b1;
                                end
                            end
                            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_POW:
                            begin
                                if (count_reg < TWO_C)
                                    res_status_reg <= ST_UNDER;
                                else
                                    state_reg <= S_RDB;
                            end
                            CMD_FIN:
                            begin
                                if (count_reg == '0)
                                    res_status_reg <= ST_NOINPUT;
                                else if (count_reg > CW'(1))
                                    res_status_reg <= ST_UNUSED;
                                else
                                    state_reg <= S_RDT;
                            end
                            default:
                            begin
                                new_count_reg <= count_reg;
                                if (count_reg != '0)
                                    state_reg <= S_RDT;
                            end
                        endcase
                    end
                end
                S_RDB:
                    state_reg <= S_RDA;
                S_RDA:
                begin
                    b_reg     <= rd_data_reg;
                    state_reg <= S_OPA;
                end
                S_OPA:
                begin
                    a_reg     <= rd_data_reg;
                    state_reg <= S_EXEC;
                end
                S_RDT:
                    state_reg <= S_TOP;
                S_TOP:
                begin
                    res_value_reg <= rd_data_reg;
                    if (cmd_reg == CMD_FIN)
                    begin
                        res_status_reg <= ST_FINAL;
                        new_count_reg  <= '0;
                    end
                    state_reg <= S_DONE;
                end
                S_EXEC:
                begin
                    new_count_reg <= cm1;
                    state_reg     <= S_DONE;
                    unique case (cmd_reg)
                        CMD_ADD:
                        begin
                            res_value_reg <= sat33(sum33);
                            wr_reg        <= 1'b1;
                        end
                        CMD_SUB:
                        begin
                            res_value_reg <= sat33(diff33);
                            wr_reg        <= 1'b1;
                        end
                        CMD_MUL:
                        begin
                            acc_reg       <= mag_a;
                            base_reg      <= mag_b;
                            phase_acc_reg <= 1'b1;
                            neg_reg       <= a_reg[31] ^ b_reg[31];
                            state_reg     <= S_MUL;
                        end
                        CMD_DIV:
                        begin
                            if (b_reg == '0)
                            begin
                                res_status_reg <= ST_DIVZ;
                                new_count_reg  <= '0;
                            end
                            else
                            begin
                                div_num_reg   <= quot_num;
                                div_den_reg   <= mag_b;
                                div_start_reg <= 1'b1;
                                neg_reg       <= a_reg[31] ^ b_reg[31];
                                state_reg     <= S_DIV;
                            end
                        end
                        CMD_POW:
                        begin
                            if (bad)
                            begin
                                res_status_reg <= ST_NONWHOLE;
                                new_count_reg  <= '0;
                            end
                            else
                            begin
                                e_reg     <= pe;
                                neg_reg   <= a_reg[31] & pe[0];
                                bneg_reg  <= b_reg[31];
                                acc_reg   <= ONE;
                                base_reg  <= mag_a;
                                state_reg <= S_POW;
                            end
                        end
                        default:
                        begin
                            res_status_reg <= ST_UNDER;
                            new_count_reg  <= '0;
                        end
                    endcase
                end
                S_MUL:
                begin
                    prod_reg  <= prod_c;
                    state_reg <= S_MRND;
                end
                S_MRND:
                begin
                    if (cmd_reg == CMD_MUL)
                    begin
                        res_value_reg <= from_mag(neg_reg, mul_r);
                        wr_reg        <= 1'b1;
                        state_reg     <= S_DONE;
                    end
                    else if (phase_acc_reg)
                    begin
                        acc_reg <= mul_r;
                        e_reg   <= e_shift;
                        if (e_shift != '0)
                        begin
                            phase_acc_reg <= 1'b0;
                            state_reg     <= S_MUL;
                        end
                        else
                            state_reg <= S_POW;
                    end
                    else
                    begin
                        base_reg  <= mul_r;
                        state_reg <= S_POW;
                    end
                end
                S_POW:
                begin
                    if (e_reg == '0)
                    begin
                        if (bneg_reg && acc_reg != '0)
                        begin
                            div_num_reg   <= recip_num;
                            div_den_reg   <= acc_reg;
                            div_start_reg <= 1'b1;
                            state_reg     <= S_DIV;
                        end
                        else
                        begin
                            // A zero result under a negative power saturates.
                            res_value_reg <= from_mag(neg_reg, bneg_reg ? MAG_LIMIT : acc_reg);
                            wr_reg        <= 1'b1;
                            state_reg     <= S_DONE;
                        end
                    end
                    else if (e_reg[0])
                    begin
                        phase_acc_reg <= 1'b1;
                        state_reg     <= S_MUL;
                    end
                    else
                    begin
                        e_reg <= e_shift;
                        if (e_shift != '0)
                        begin
                            phase_acc_reg <= 1'b0;
                            state_reg     <= S_MUL;
                        end
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        res_value_reg <= from_mag(neg_reg, qc);
                        wr_reg        <= 1'b1;
                        state_reg     <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= res_status_reg;
                        out_value_reg  <= (res_status_reg == ST_OK || res_status_reg == ST_FINAL)
                                          ? res_value_reg : 32'd0;
                        out_depth_reg  <= new_count_reg[1:0];
                        count_reg      <= new_count_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_depth_reg, out_value_reg};
    assign m_tuser  = out_status_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("stack count beyond depth");

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !div_busy)
        else $error("divider busy while idle");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside divide state");

    a_err_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg != ST_OK) |-> (out_depth_reg == 2'd0))
        else $error("stack not cleared after error or finish");

endmodule

`default_nettype wire

// File: tb/rpn_stack_calculator_unit_test.sv
module rpn_stack_calculator_unit_test;
    import rpn_pkg::*;

    localparam int TOL_RESET = 6;

    typedef struct {
        status_t     st;
        logic [31:0] val;
        logic [1:0]  dep;
    } calc_res_t;

    typedef struct {
        cmd_t        cmd;
        logic [31:0] opnd;
        bit          typed;
        status_t     st;
        logic [31:0] val;
        logic [1:0]  dep;
    } dir_row_t;

    localparam int DIR_ROWS = 34;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [14:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic [2:0]  m_tuser;

    // Predictor state.
    logic signed [31:0] calc_stk [0:2];
    int                 calc_cnt;
    longint unsigned    calc_tol;

    calc_res_t result_q [$];
    int        fail_cnt;
    int        burst_left;
    int        ready_pct;
    int        ready_hold;

    dir_row_t dir_tab [0:DIR_ROWS-1] = '{
        '{CMD_FIN,  32'h0,        1'b1, ST_NOINPUT,  32'h0,        2'd0},
        '{CMD_ADD,  32'h0,        1'b1, ST_UNDER,    32'h0,        2'd0},
        '{CMD_PUSH, 32'h7FFFFFFF, 1'b1, ST_OK,       32'h7FFFFFFF, 2'd1},
        '{CMD_PUSH, 32'h7FFFFFFF, 1'b1, ST_OK,       32'h7FFFFFFF, 2'd2},
        '{CMD_ADD,  32'h0,        1'b1, ST_OK,       32'h7FFFFFFF, 2'd1},
        '{CMD_PUSH, 32'h80000000, 1'b1, ST_OK,       32'h80000000, 2'd2},
        '{CMD_SUB,  32'h0,        1'b1, ST_OK,       32'h7FFFFFFF, 2'd1},
        '{CMD_PUSH, 32'h1,        1'b1, ST_OK,       32'h1,        2'd2},
        '{CMD_PUSH, 32'h2,        1'b1, ST_OK,       32'h2,        2'd3},
        '{CMD_PUSH, 32'h3,        1'b1, ST_OVER,     32'h0,        2'd0},
        '{CMD_PUSH, 32'h10000,    1'b0, ST_OK,       32'h0,        2'd0},
        '{CMD_PUSH, 32'h0,        1'b0, ST_OK,       32'h0,        2'd0},
        '{CMD_DIV,  32'h0,        1'b1, ST_DIVZ,     32'h0,        2'd0},
        '{CMD_PUSH, 32'h10000,    1'b0, ST_OK,       32'h0,        2'd0},
        '{CMD_PUSH, 32'h18000,    1'b0, ST_OK,       32'h0,        2'd0},
        '{CMD_POW,  32'h0,        1'b1, ST_NONWHOLE, 32'h0,        2'd0},
        '{CMD_PUSH, 32'h0,        1'b0, ST_OK,       32'h0,        2'd0},
        '{CMD_PUSH, 32'hFFFF0000, 1'b0, ST_OK,       32'h0,        2'd0},
        '{CMD_POW,  32'h0,        1'b0, ST_OK,       32'h0,        2'd0},
        '{CMD_FIN,  32'h0,        1'b0, ST_OK,       32'h0,        2'd0},
        '{CMD_PUSH, 32'h0,        1'b0, ST_OK,       32'h0,        2'd0},
        '{CMD_PUSH, 32'h0,        1'b0, ST_OK,       32'h0,        2'd0},
        '{CMD_POW,  32'h0,        1'b1, ST_OK,       32'h10000,    2'd1},
        '{CMD_FIN,  32'h0,        1'b1, ST_FINAL,    32'h10000,    2'd0},
        '{CMD_PUSH, 32'h80000000, 1'b0, ST_OK,       32'h0,        2'd0},
        '{CMD_PUSH, 32'h80000000, 1'b0, ST_OK,       32'h0,        2'd0},
        '{CMD_MUL,  32'h0,        1'b0, ST_OK,       32'h0,        2'd0},
        '{CMD_PUSH, 32'hFFFD0000, 1'b0, ST_OK,       32'h0,        2'd0},
        '{CMD_PUSH, 32'h30000,    1'b0, ST_OK,       32'h0,        2'd0},
        '{CMD_POW,  32'h0,        1'b0, ST_OK,       32'h0,        2'd0},
        '{CMD_PUSH, 32'h20000,    1'b0, ST_OK,       32'h0,        2'd0},
        '{CMD_DIV,  32'h0,        1'b0, ST_OK,       32'h0,        2'd0},
        '{CMD_FIN,  32'h0,        1'b1, ST_UNUSED,   32'h0,        2'd0},
        '{CMD_NOP,  32'h0,        1'b1, ST_OK,       32'h0,        2'd0}
    };

    rpn_stack_calculator_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #5 clk = ~clk;

    function automatic longint unsigned fix_mag(longint v);
        return (v < 0) ? longint'(-v) : v;
    endfunction

    function automatic longint unsigned clamp_mag(longint unsigned m);
        return (m > 64'h8000_0000) ? 64'h8000_0000 : m;
    endfunction

    function automatic logic [31:0] sat_fix(bit neg, longint unsigned m);
        longint unsigned nm;
        if (neg)
        begin
            nm = -m;
            return (m >= 64'h8000_0000) ? 32'h8000_0000 : nm[31:0];
        end
        return (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
    endfunction

    function automatic longint unsigned mul_fix(longint unsigned a, longint unsigned b);
        longint unsigned p;
        p = a * b;
        return clamp_mag((p + 64'h8000) >> 16);
    endfunction

    function automatic logic [31:0] pow_fix(longint a, longint b, output bit bad);
        longint unsigned mb, frac, e, frac_dist, base, acc;
        bit neg;
        mb        = fix_mag(b);
        frac      = mb & 64'hFFFF;
        e         = mb >> 16;
        frac_dist = frac;
        base      = clamp_mag(fix_mag(a));
        acc       = 64'h10000;
        // The exponent rounds half away from zero to its whole number.
        if (frac >= 64'h8000)
        begin
            e++;
            frac_dist = 64'h10000 - frac;
        end
        bad = frac_dist > calc_tol;
        if (bad)
            return 32'h0;
        neg = (a < 0) && e[0];
        while (e != 0)
        begin
            if (e[0])
                acc = mul_fix(acc, base);
            e = e >> 1;
            if (e != 0)
                base = mul_fix(base, base);
        end
        if (b < 0)
        begin
            if (acc == 0)
                acc = 64'h8000_0000;
            else
                acc = clamp_mag((64'h1_0000_0000 + acc / 2) / acc);
        end
        return sat_fix(neg, acc);
    endfunction

    function automatic calc_res_t calc_step(cmd_t cmd, logic [31:0] opnd);
        calc_res_t       res;
        longint          a, b, s;
        longint unsigned mb;
        logic [31:0]     r;
        bit              bad;
        res.st  = ST_OK;
        res.val = 32'h0;
        r       = 32'h0;
        case (cmd) inside
            CMD_PUSH:
            begin
                if (calc_cnt >= 3)
                    res.st = ST_OVER;
                else
                begin
                    calc_stk[calc_cnt] = opnd;
                    calc_cnt++;
                end
            end
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_POW:
            begin
                if (calc_cnt < 2)
                    res.st = ST_UNDER;
                else
                begin
                    b = calc_stk[calc_cnt-1];
                    a = calc_stk[calc_cnt-2];
                    calc_cnt -= 2;
                    case (cmd)
                        CMD_ADD:
                        begin
                            s = a + b;
                            r = sat_fix(s < 0, fix_mag(s));
                        end
                        CMD_SUB:
                        begin
                            s = a - b;
                            r = sat_fix(s < 0, fix_mag(s));
                        end
                        CMD_MUL:
                            r = sat_fix((a < 0) != (b < 0), mul_fix(fix_mag(a), fix_mag(b)));
                        CMD_DIV:
                        begin
                            if (b == 0)
                                res.st = ST_DIVZ;
                            else
                            begin
                                mb = fix_mag(b);
                                r  = sat_fix((a < 0) != (b < 0),
                                             clamp_mag(((fix_mag(a) << 16) + mb / 2) / mb));
                            end
                        end
                        default:
                        begin
                            r = pow_fix(a, b, bad);
                            if (bad)
                                res.st = ST_NONWHOLE;
                        end
                    endcase
                    if (res.st == ST_OK)
                    begin
                        calc_stk[calc_cnt] = r;
                        calc_cnt++;
                    end
                end
            end
            CMD_FIN:
            begin
                if (calc_cnt == 0)
                    res.st = ST_NOINPUT;
                else if (calc_cnt > 1)
                    res.st = ST_UNUSED;
                else
                begin
                    res.st  = ST_FINAL;
                    res.val = calc_stk[0];
                end
                calc_cnt = 0;
            end
            default:
                ;
        endcase
        if (res.st >= ST_UNDER)
            calc_cnt = 0;
        if (res.st == ST_OK && calc_cnt > 0)
            res.val = calc_stk[calc_cnt-1];
        res.dep = calc_cnt[1:0];
        return res;
    endfunction

    // Drives one item in bursts with random gaps and records its expected result on transfer.
    task automatic send_cmd(cmd_t cmd, logic [31:0] opnd, bit typed, calc_res_t typed_res);
        calc_res_t res;
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 40);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= opnd;
        do
            @(posedge clk);
        while (!s_tready);
        burst_left--;
        res = calc_step(cmd, opnd);
        result_q.push_back(typed ? typed_res : res);
    endtask

    task automatic write_tolerance(logic [14:0] tol);
        s_tvalid   <= 1'b0;
        burst_left = 0;
        wait (result_q.size() == 0);
        repeat (200) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= tol;
        @(posedge clk);
        cfg_we   <= 1'b0;
        calc_tol = tol;
    endtask

    function automatic logic [31:0] pick_operand();
        int k;
        k = $urandom_range(0, 99);
        if (k < 35)
            return (($urandom_range(0, 10) - 5) << 16) + $urandom_range(0, 16) - 8;
        if (k < 70)
            return $urandom_range(0, 20'hFFFFF) - 32'h80000;
        if (k < 80)
        begin
            case ($urandom_range(0, 3))
                0: return 32'h7FFFFFFF;
                1: return 32'h80000000;
                2: return 32'h0;
                default: return 32'h10000;
            endcase
        end
        return $urandom;
    endfunction

    task automatic send_random();
        int        r;
        cmd_t      cmd;
        calc_res_t none;
        none = '{ST_OK, 32'h0, 2'd0};
        r = $urandom_range(0, 99);
        if (r < 8)
            cmd = cmd_t'($urandom_range(0, 7));
        else if (calc_cnt == 0)
            cmd = CMD_PUSH;
        else if (calc_cnt == 1)
            cmd = (r < 75) ? CMD_PUSH : CMD_FIN;
        else if (calc_cnt == 2)
            cmd = (r < 45) ? CMD_PUSH : cmd_t'($urandom_range(1, 5));
        else
            cmd = (r < 12) ? CMD_PUSH : (r < 16) ? CMD_FIN : cmd_t'($urandom_range(1, 5));
        send_cmd(cmd, pick_operand(), 1'b0, none);
    endtask

    // The receiver stalls with a readiness that changes from stretch to stretch.
    always @(posedge clk)
    begin
        calc_res_t exp_res;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (result_q.size() == 0)
            begin
                fail_cnt++;
                if (fail_cnt <= 10)
                    $display("Unexpected result transfer: status %0d value %h depth %0d",
                             m_tuser, m_tdata[31:0], m_tdata[33:32]);
            end
            else
            begin
                exp_res = result_q.pop_front();
                if (m_tuser !== exp_res.st || m_tdata[31:0] !== exp_res.val
                    || m_tdata[33:32] !== exp_res.dep)
                begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("Mismatch: expected status %0d value %h depth %0d, got %0d %h %0d",
                                 exp_res.st, exp_res.val, exp_res.dep,
                                 m_tuser, m_tdata[31:0], m_tdata[33:32]);
                end
            end
        end
        if (ready_hold == 0)
        begin
            case ($urandom_range(0, 3))
                0: ready_pct = 100;
                1: ready_pct = 70;
                2: ready_pct = 30;
                default: ready_pct = 90;
            endcase
            ready_hold = $urandom_range(64, 256);
        end
        ready_hold--;
        m_tready <= ($urandom_range(0, 99) < ready_pct);
    end

    initial
    begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        logic [14:0] tols [0:3];
        calc_res_t   row_res;
        clk        = 1'b0;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        m_tready   = 1'b0;
        fail_cnt   = 0;
        burst_left = 0;
        ready_pct  = 100;
        ready_hold = 0;
        calc_cnt   = 0;
        calc_tol   = TOL_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            row_res = '{dir_tab[i].st, dir_tab[i].val, dir_tab[i].dep};
            send_cmd(dir_tab[i].cmd, dir_tab[i].opnd, dir_tab[i].typed, row_res);
        end

        tols[0] = 15'd0;
        tols[1] = 15'h7FFF;
        tols[2] = 15'($urandom_range(1, 64));
        tols[3] = 15'($urandom);
        for (int p = 0; p < 4; p++)
        begin
            write_tolerance(tols[p]);
            repeat (280) send_random();
        end

        s_tvalid <= 1'b0;
        wait (result_q.size() == 0);
        repeat (200) @(posedge clk);
        if (fail_cnt == 0 && result_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/rpn_pkg.sv
rtl/core/rpn_div.sv
rtl/core/rpn_stack_calculator_unit.sv
tb/rpn_stack_calculator_unit_test.sv
